/* hw/rtl/trrt_pkg.sv */
// Shared types, codes and helper functions of the rename and reorder tracker.
// Used by every module of the block; no dependencies.
`timescale 1ns / 1ps

package trrt_pkg;

  // Fixed architectural sizes
  localparam int ARCH_REGS    = 32;
  localparam int REG_W        = 5;
  localparam int NUM_STATIONS = 6;
  localparam int REM_W        = 3;

  // Opcode and funct7 values used for classification
  localparam logic [6:0] OP_ALU_REG = 7'h33;
  localparam logic [6:0] F7_MULDIV  = 7'h01;
  localparam logic [6:0] OP_LOAD    = 7'h03;
  localparam logic [6:0] OP_STORE   = 7'h23;

  typedef enum logic [1:0] {
    ACT_ISSUE  = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_BCAST  = 2'd2,
    ACT_COMMIT = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CLS_INT   = 2'd0,
    CLS_MUL   = 2'd1,
    CLS_LOAD  = 2'd2,
    CLS_STORE = 2'd3
  } cls_t;

  // Station pool: two integer, two multiply, one load, one store
  localparam cls_t STATION_CLASS [NUM_STATIONS] = '{
    CLS_INT, CLS_INT, CLS_MUL, CLS_MUL, CLS_LOAD, CLS_STORE
  };

  // Ring control for one beat
  typedef struct packed {
    logic issue;
    logic commit;
    logic rd_en;
  } ring_ctl_t;

  // Station control for one beat
  typedef struct packed {
    logic issue;
    logic tick;
    logic bcast;
    cls_t cls;
  } st_ctl_t;

  function automatic cls_t classify(input logic [6:0] op, input logic [6:0] f7);
    cls_t c;
    if (op == OP_ALU_REG && f7 == F7_MULDIV) c = CLS_MUL;
    else if (op == OP_LOAD)                  c = CLS_LOAD;
    else if (op == OP_STORE)                 c = CLS_STORE;
    else                                     c = CLS_INT;
    return c;
  endfunction

  function automatic logic [REM_W-1:0] latency_of(input cls_t c);
    logic [REM_W-1:0] l;
    case (c) inside
      CLS_MUL:              l = REM_W'(4);
      CLS_LOAD, CLS_STORE:  l = REM_W'(2);
      default:              l = REM_W'(1);
    endcase
    return l;
  endfunction

endpackage

/* hw/rtl/trrt_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on nothing but the field widths of the tracker's items.
`timescale 1ns / 1ps

interface trrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  opcode;
  logic [6:0]  funct_seven;
  logic [4:0]  dst_reg;
  logic [4:0]  src_a;
  logic [4:0]  src_b;
  logic [31:0] instr_pc;

  modport source (output valid, action, opcode, funct_seven, dst_reg, src_a, src_b,
                  instr_pc, input ready);
  modport sink   (input valid, action, opcode, funct_seven, dst_reg, src_a, src_b,
                  instr_pc, output ready);
endinterface

interface trrt_out_if;
  logic        valid;
  logic        ready;
  logic        issued;
  logic        retire_valid;
  logic [4:0]  retire_reg;
  logic [31:0] retire_pc;

  modport source (output valid, issued, retire_valid, retire_reg, retire_pc, input ready);
  modport sink   (input valid, issued, retire_valid, retire_reg, retire_pc, output ready);
endinterface

/* hw/rtl/trrt_rename.sv */
// Rename table: architectural register to newest in-flight ring slot.
// Depends on trrt_pkg.
`timescale 1ns / 1ps

module trrt_rename #(
  parameter int RING_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [trrt_pkg::REG_W-1:0]            src_a,
  input  logic [trrt_pkg::REG_W-1:0]            src_b,
  output logic                                  map_a_vld,
  output logic [$clog2(RING_DEPTH)-1:0]         map_a_tag,
  output logic                                  map_b_vld,
  output logic [$clog2(RING_DEPTH)-1:0]         map_b_tag,
  input  logic                                  wr_en,
  input  logic [trrt_pkg::REG_W-1:0]            wr_reg,
  input  logic [$clog2(RING_DEPTH)-1:0]         wr_tag,
  input  logic                                  clr_en,
  input  logic [$clog2(RING_DEPTH)-1:0]         clr_tag
);

  localparam int TW = $clog2(RING_DEPTH);

  logic [trrt_pkg::ARCH_REGS-1:0] vld_r;
  logic [TW-1:0]                  tag_r [trrt_pkg::ARCH_REGS];

  // Source lookups see the table before this beat's rename
  assign map_a_vld = vld_r[src_a];
  assign map_a_tag = tag_r[src_a];
  assign map_b_vld = vld_r[src_b];
  assign map_b_tag = tag_r[src_b];

  // Valid bits: set on rename, cleared when the named slot retires.
  // Only the retiring instruction's own register can still name its slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int r = 1; r < trrt_pkg::ARCH_REGS; r++) begin
        if (wr_en && wr_reg == trrt_pkg::REG_W'(r)) begin
          vld_r[r] <= 1'b1;
        end else if (clr_en && vld_r[r] && tag_r[r] == clr_tag) begin
          vld_r[r] <= 1'b0;
        end
      end
      vld_r[0] <= 1'b0;
    end
  end

  // Tag payload
  always_ff @(posedge clk) begin
    if (wr_en && wr_reg != '0) begin
      tag_r[wr_reg] <= wr_tag;
    end
  end

endmodule

/* hw/rtl/trrt_ring.sv */
// Reorder ring: head/tail/count, per-slot ready bits and a pc/dest memory
// whose registered read port feeds the retire fields. Depends on trrt_pkg.
`timescale 1ns / 1ps

module trrt_ring #(
  parameter int RING_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  trrt_pkg::ring_ctl_t                   ctl,
  input  logic [31:0]                           issue_pc,
  input  logic [trrt_pkg::REG_W-1:0]            issue_dest,
  input  logic [RING_DEPTH-1:0]                 set_ready,
  input  logic [$clog2(RING_DEPTH)-1:0]         query_a,
  input  logic [$clog2(RING_DEPTH)-1:0]         query_b,
  output logic                                  ready_a,
  output logic                                  ready_b,
  output logic [$clog2(RING_DEPTH)-1:0]         tail,
  output logic [$clog2(RING_DEPTH)-1:0]         head,
  output logic                                  full,
  output logic                                  commit_ok,
  output logic [31:0]                           head_pc_q,
  output logic [trrt_pkg::REG_W-1:0]            head_dest_q
);

  localparam int TW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);

  logic [TW-1:0]             head_r, head_nxt;
  logic [TW-1:0]             tail_r, tail_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [RING_DEPTH-1:0]     ready_r, ready_nxt;

  logic [31:0]               pc_mem   [RING_DEPTH];
  logic [trrt_pkg::REG_W-1:0] dest_mem [RING_DEPTH];

  logic [31:0]                head_pc_r;
  logic [trrt_pkg::REG_W-1:0] head_dest_r;

  assign head      = head_r;
  assign tail      = tail_r;
  assign full      = (count_r == CW'(RING_DEPTH));
  assign commit_ok = (count_r != '0) && ready_r[head_r];

  // The tail slot is free and about to be reloaded, so it never counts as ready
  assign ready_a = ready_r[query_a] && (query_a != tail_r);
  assign ready_b = ready_r[query_b] && (query_b != tail_r);

  // Pointer and ready-bit update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ready_nxt = ready_r | set_ready;
    if (ctl.issue) begin
      ready_nxt[tail_r] = 1'b0;
      tail_nxt  = (tail_r == TW'(RING_DEPTH - 1)) ? '0 : tail_r + TW'(1);
      count_nxt = count_r + CW'(1);
    end
    if (ctl.commit) begin
      ready_nxt[head_r] = 1'b0;
      head_nxt  = (head_r == TW'(RING_DEPTH - 1)) ? '0 : head_r + TW'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      ready_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      ready_r <= ready_nxt;
    end
  end

  // pc/dest memory: written at the tail on issue, read at the head per beat
  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      pc_mem[tail_r]   <= issue_pc;
      dest_mem[tail_r] <= issue_dest;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      head_pc_r   <= pc_mem[head_r];
      head_dest_r <= dest_mem[head_r];
    end
  end

  assign head_pc_q   = head_pc_r;
  assign head_dest_q = head_dest_r;

endmodule

/* hw/rtl/trrt_stations.sv */
// Six reservation stations: allocation, countdown and completion broadcast.
// Depends on trrt_pkg.
`timescale 1ns / 1ps

module trrt_stations #(
  parameter int RING_DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  trrt_pkg::st_ctl_t                     ctl,
  input  logic [$clog2(RING_DEPTH)-1:0]         issue_tag,
  input  logic                                  issue_wait_a,
  input  logic [$clog2(RING_DEPTH)-1:0]         issue_tag_a,
  input  logic                                  issue_wait_b,
  input  logic [$clog2(RING_DEPTH)-1:0]         issue_tag_b,
  output logic                                  avail,
  output logic [RING_DEPTH-1:0]                 set_ready
);

  localparam int TW = $clog2(RING_DEPTH);
  localparam int NS = trrt_pkg::NUM_STATIONS;

  logic [NS-1:0]              busy_r, wait_a_r, wait_b_r;
  logic [TW-1:0]              tag_a_r [NS];
  logic [TW-1:0]              tag_b_r [NS];
  logic [TW-1:0]              dtag_r  [NS];
  logic [trrt_pkg::REM_W-1:0] rem_r   [NS];

  logic [NS-1:0] pick;
  logic [NS-1:0] done;
  logic [NS-1:0] hit_a, hit_b;

  // First free station of the requested class
  always_comb begin
    logic found;
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < NS; i++) begin
      if (!found && !busy_r[i] && trrt_pkg::STATION_CLASS[i] == ctl.cls) begin
        pick[i] = 1'b1;
        found   = 1'b1;
      end
    end
  end
  assign avail = |pick;

  // Completion: finished stations mark their slots ready and wake waiters
  always_comb begin
    set_ready = '0;
    for (int i = 0; i < NS; i++) begin
      done[i] = ctl.bcast && busy_r[i] && rem_r[i] == '0;
      if (done[i]) set_ready[dtag_r[i]] = 1'b1;
    end
    for (int j = 0; j < NS; j++) begin
      hit_a[j] = 1'b0;
      hit_b[j] = 1'b0;
      for (int i = 0; i < NS; i++) begin
        if (done[i] && dtag_r[i] == tag_a_r[j]) hit_a[j] = 1'b1;
        if (done[i] && dtag_r[i] == tag_b_r[j]) hit_b[j] = 1'b1;
      end
    end
  end

  // Control state per station
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= '0;
      wait_a_r <= '0;
      wait_b_r <= '0;
      for (int i = 0; i < NS; i++) rem_r[i] <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (ctl.issue && pick[i]) begin
          busy_r[i]   <= 1'b1;
          wait_a_r[i] <= issue_wait_a;
          wait_b_r[i] <= issue_wait_b;
          rem_r[i]    <= trrt_pkg::latency_of(ctl.cls);
        end else if (done[i]) begin
          busy_r[i]   <= 1'b0;
          wait_a_r[i] <= 1'b0;
          wait_b_r[i] <= 1'b0;
          rem_r[i]    <= '0;
        end else begin
          if (busy_r[i] && hit_a[i]) wait_a_r[i] <= 1'b0;
          if (busy_r[i] && hit_b[i]) wait_b_r[i] <= 1'b0;
          if (ctl.tick && busy_r[i] && !wait_a_r[i] && !wait_b_r[i] && rem_r[i] != '0) begin
            rem_r[i] <= rem_r[i] - trrt_pkg::REM_W'(1);
          end
        end
      end
    end
  end

  // Tag payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < NS; i++) begin
      if (ctl.issue && pick[i]) begin
        dtag_r[i]  <= issue_tag;
        tag_a_r[i] <= issue_tag_a;
        tag_b_r[i] <= issue_tag_b;
      end
    end
  end

endmodule

/* hw/rtl/tomasulo_rename_and_reorder_tracker_unit.sv */
// Top level of the rename and reorder tracker: input register, action decode,
// result register. Depends on trrt_pkg, trrt_if, trrt_rename, trrt_ring, trrt_stations.
`timescale 1ns / 1ps

// Tag tracker for an out-of-order core: six reservation stations (two integer,
// two multiply, one load, one store), a reorder ring of RING_DEPTH slots and a
// 32-entry rename table. Each input beat carries one action (issue, execute
// tick, result broadcast, commit) and yields exactly one result beat. A beat
// is captured in the input register; during the following cycle its whole
// action is worked out, and at the next edge it is applied to the state and
// its result is loaded into the output register. One beat per cycle is
// sustained, with the output handshake as the only thing that holds the flow.
// No clearing pass is needed after reset.

module tomasulo_rename_and_reorder_tracker_unit #(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  trrt_in_if.sink    in_ch,
  trrt_out_if.source out_ch
);

  localparam int TW = $clog2(RING_DEPTH);

  // Input register
  logic                       in_vld_r;
  trrt_pkg::action_t          act_r;
  logic [6:0]                 opcode_r;
  logic [6:0]                 f7_r;
  logic [trrt_pkg::REG_W-1:0] dest_r;
  logic [trrt_pkg::REG_W-1:0] src_a_r;
  logic [trrt_pkg::REG_W-1:0] src_b_r;
  logic [31:0]                pc_r;

  // Result register
  logic out_vld_r;
  logic issued_r;
  logic retire_vld_r;

  logic adv;
  logic go_issue, go_tick, go_bcast, go_commit;
  logic issue_fire, commit_fire;
  trrt_pkg::cls_t cls;

  logic                  map_a_vld, map_b_vld;
  logic [TW-1:0]         map_a_tag, map_b_tag;
  logic                  rdy_a, rdy_b;
  logic [TW-1:0]         tail, head;
  logic                  full, commit_ok, st_avail;
  logic [RING_DEPTH-1:0] set_ready;
  logic [31:0]           head_pc_q;
  logic [trrt_pkg::REG_W-1:0] head_dest_q;
  logic                  wait_a, wait_b;

  trrt_pkg::ring_ctl_t ring_ctl;
  trrt_pkg::st_ctl_t   st_ctl;

  // Handshake: the held beat moves on when the result register is free
  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      act_r    <= trrt_pkg::action_t'(in_ch.action);
      opcode_r <= in_ch.opcode;
      f7_r     <= in_ch.funct_seven;
      dest_r   <= in_ch.dst_reg;
      src_a_r  <= in_ch.src_a;
      src_b_r  <= in_ch.src_b;
      pc_r     <= in_ch.instr_pc;
    end
  end

  // Action decode
  always_comb begin
    go_issue  = 1'b0;
    go_tick   = 1'b0;
    go_bcast  = 1'b0;
    go_commit = 1'b0;
    unique case (act_r)
      trrt_pkg::ACT_ISSUE:  go_issue  = adv;
      trrt_pkg::ACT_TICK:   go_tick   = adv;
      trrt_pkg::ACT_BCAST:  go_bcast  = adv;
      trrt_pkg::ACT_COMMIT: go_commit = adv;
      default: ;
    endcase
  end

  assign cls         = trrt_pkg::classify(opcode_r, f7_r);
  assign issue_fire  = go_issue && st_avail && !full;
  assign commit_fire = go_commit && commit_ok;

  // A source waits only while its renamed slot has not produced a result
  assign wait_a = (src_a_r != '0) && map_a_vld && !rdy_a;
  assign wait_b = (src_b_r != '0) && map_b_vld && !rdy_b;

  assign ring_ctl = '{issue: issue_fire, commit: commit_fire, rd_en: adv};
  assign st_ctl   = '{issue: issue_fire, tick: go_tick, bcast: go_bcast, cls: cls};

  trrt_rename #(.RING_DEPTH(RING_DEPTH)) u_rename (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_a     (src_a_r),
    .src_b     (src_b_r),
    .map_a_vld (map_a_vld),
    .map_a_tag (map_a_tag),
    .map_b_vld (map_b_vld),
    .map_b_tag (map_b_tag),
    .wr_en     (issue_fire),
    .wr_reg    (dest_r),
    .wr_tag    (tail),
    .clr_en    (commit_fire),
    .clr_tag   (head)
  );

  trrt_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ring_ctl),
    .issue_pc    (pc_r),
    .issue_dest  (dest_r),
    .set_ready   (set_ready),
    .query_a     (map_a_tag),
    .query_b     (map_b_tag),
    .ready_a     (rdy_a),
    .ready_b     (rdy_b),
    .tail        (tail),
    .head        (head),
    .full        (full),
    .commit_ok   (commit_ok),
    .head_pc_q   (head_pc_q),
    .head_dest_q (head_dest_q)
  );

  trrt_stations #(.RING_DEPTH(RING_DEPTH)) u_stations (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (st_ctl),
    .issue_tag    (tail),
    .issue_wait_a (wait_a),
    .issue_tag_a  (map_a_tag),
    .issue_wait_b (wait_b),
    .issue_tag_b  (map_b_tag),
    .avail        (st_avail),
    .set_ready    (set_ready)
  );

  // Result register; retire pc/dest come from the ring's registered read port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      issued_r     <= issue_fire;
      retire_vld_r <= commit_fire;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.issued       = issued_r;
  assign out_ch.retire_valid = retire_vld_r;
  assign out_ch.retire_reg   = retire_vld_r ? head_dest_q : '0;
  assign out_ch.retire_pc    = retire_vld_r ? head_pc_q : 32'd0;

endmodule
